// ===== hw/rtl/sst_pkg.sv =====
// shared types, constants and tap table for the six-tap subpixel interpolator
`default_nettype none

package sst_pkg;

    localparam int PIX_W       = 8;
    localparam int TAPS        = 6;
    localparam int HIST_ROWS   = 5;
    localparam int BLK         = 4;
    localparam int WIN_ROWS    = 9;
    localparam int ROUND_ADD   = 64;
    localparam int ROUND_SHIFT = 7;
    localparam int COEF_W      = 9;
    localparam int ACC_W       = 20;
    localparam int CNT_W       = 4;
    localparam int FRAC_W      = 3;
    localparam int ROW_W       = 2;

    // stream packing
    localparam int IN_TDATA_W    = 80;
    localparam int FRAC_COL_LSB  = WIN_ROWS * PIX_W;
    localparam int FRAC_ROW_LSB  = FRAC_COL_LSB + FRAC_W;
    localparam int OUT_TDATA_W   = 40;
    localparam int OUT_ROW_LSB   = BLK * PIX_W;

    // filter_kind codes
    localparam logic FK_SIXTAP   = 1'b0;
    localparam logic FK_BILINEAR = 1'b1;

    typedef logic [PIX_W-1:0]         t_pix;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [0:TAPS-1]         t_taps;
    typedef t_pix  [0:TAPS-1]         t_lane_in;
    typedef t_pix  [0:WIN_ROWS-1]     t_win;
    typedef t_pix  [0:BLK-1]          t_blk_row;

    typedef struct packed {
        logic              emit;
        logic [ROW_W-1:0]  out_row;
        logic              last;
        logic [FRAC_W-1:0] frac_row;
    } t_tag;

    localparam t_taps TAP_ROM [0:1][0:7] = '{
        '{
            '{ 9'sd0,   9'sd0,  9'sd128,  9'sd0,    9'sd0,  9'sd0},
            '{ 9'sd0,  -9'sd6,  9'sd123,  9'sd12,  -9'sd1,  9'sd0},
            '{ 9'sd2, -9'sd11,  9'sd108,  9'sd36,  -9'sd8,  9'sd1},
            '{ 9'sd0,  -9'sd9,  9'sd93,   9'sd50,  -9'sd6,  9'sd0},
            '{ 9'sd3, -9'sd16,  9'sd77,   9'sd77, -9'sd16,  9'sd3},
            '{ 9'sd0,  -9'sd6,  9'sd50,   9'sd93,  -9'sd9,  9'sd0},
            '{ 9'sd1,  -9'sd8,  9'sd36,   9'sd108, -9'sd11, 9'sd2},
            '{ 9'sd0,  -9'sd1,  9'sd12,   9'sd123, -9'sd6,  9'sd0}
        },
        '{
            '{ 9'sd0, 9'sd0, 9'sd128, 9'sd0,   9'sd0, 9'sd0},
            '{ 9'sd0, 9'sd0, 9'sd112, 9'sd16,  9'sd0, 9'sd0},
            '{ 9'sd0, 9'sd0, 9'sd96,  9'sd32,  9'sd0, 9'sd0},
            '{ 9'sd0, 9'sd0, 9'sd80,  9'sd48,  9'sd0, 9'sd0},
            '{ 9'sd0, 9'sd0, 9'sd64,  9'sd64,  9'sd0, 9'sd0},
            '{ 9'sd0, 9'sd0, 9'sd48,  9'sd80,  9'sd0, 9'sd0},
            '{ 9'sd0, 9'sd0, 9'sd32,  9'sd96,  9'sd0, 9'sd0},
            '{ 9'sd0, 9'sd0, 9'sd16,  9'sd112, 9'sd0, 9'sd0}
        }
    };

    function automatic t_taps tap_lookup(input logic kind, input logic [FRAC_W-1:0] frac);
        return TAP_ROM[kind][frac];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sst_tap_filter.sv =====
// one six-tap lane: weighted sum, rounding, shift and clamp to 8 bits
`default_nettype none

module sst_tap_filter (
    input  sst_pkg::t_lane_in i_pix,
    input  sst_pkg::t_taps    i_taps,
    output sst_pkg::t_pix     o_val
);
    import sst_pkg::*;

    logic signed [ACC_W-1:0]         acc;
    logic signed [ACC_W-1:0]         rnd;
    logic [ACC_W-ROUND_SHIFT-1:0]    shifted;

    always_comb begin
        acc = '0;
        for (int k = 0; k < TAPS; k++) begin
            acc = acc + ACC_W'($signed({1'b0, i_pix[k]})) * ACC_W'($signed(i_taps[k]));
        end
        rnd     = acc + ACC_W'(ROUND_ADD);
        shifted = rnd[ACC_W-1:ROUND_SHIFT];
    end

    always_comb begin
        priority if (rnd[ACC_W-1]) begin
            o_val = '0;
        end else if (|shifted[ACC_W-ROUND_SHIFT-1:PIX_W]) begin
            o_val = '1;
        end else begin
            o_val = shifted[PIX_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sst_hpass.sv =====
// horizontal pass: four lanes over the window row, registered filtered row
`default_nettype none

module sst_hpass (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic                      i_kind,
    input  sst_pkg::t_win             i_win,
    input  logic [sst_pkg::FRAC_W-1:0] i_frac_col,
    input  sst_pkg::t_tag             i_tag,
    output sst_pkg::t_blk_row         o_cur,
    output sst_pkg::t_tag             o_tag
);
    import sst_pkg::*;

    t_taps    htaps;
    t_lane_in lane_pix [0:BLK-1];
    t_blk_row n_cur;
    t_blk_row r_cur;
    t_tag     r_tag;

    assign htaps = tap_lookup(i_kind, i_frac_col);

    // block column j uses window columns j..j+5
    always_comb begin
        for (int j = 0; j < BLK; j++) begin
            for (int k = 0; k < TAPS; k++) begin
                lane_pix[j][k] = i_win[j + k];
            end
        end
    end

    for (genvar j = 0; j < BLK; j++) begin : g_lane
        sst_tap_filter u_lane (
            .i_pix  (lane_pix[j]),
            .i_taps (htaps),
            .o_val  (n_cur[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cur <= n_cur;
            r_tag <= i_tag;
        end
    end

    assign o_cur = r_cur;
    assign o_tag = r_tag;

endmodule

`default_nettype wire

// ===== hw/rtl/sst_vpass.sv =====
// vertical pass: five-row history, four lanes, registered output row
`default_nettype none

module sst_vpass (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic                      i_kind,
    input  sst_pkg::t_blk_row         i_cur,
    input  sst_pkg::t_tag             i_tag,
    output sst_pkg::t_blk_row         o_pix,
    output logic [sst_pkg::ROW_W-1:0] o_row,
    output logic                      o_last
);
    import sst_pkg::*;

    t_taps            vtaps;
    t_lane_in         lane_pix [0:BLK-1];
    t_blk_row         n_pix;
    t_blk_row         r_hist [0:HIST_ROWS-1];
    t_blk_row         r_pix;
    logic [ROW_W-1:0] r_row;
    logic             r_last;

    assign vtaps = tap_lookup(i_kind, i_tag.frac_row);

    // oldest row first, the new filtered row as the sixth tap
    always_comb begin
        for (int j = 0; j < BLK; j++) begin
            for (int k = 0; k < HIST_ROWS; k++) begin
                lane_pix[j][k] = r_hist[k][j];
            end
            lane_pix[j][HIST_ROWS] = i_cur[j];
        end
    end

    for (genvar j = 0; j < BLK; j++) begin : g_lane
        sst_tap_filter u_lane (
            .i_pix  (lane_pix[j]),
            .i_taps (vtaps),
            .o_val  (n_pix[j])
        );
    end

    // history is fully rewritten before the first output of a block
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < HIST_ROWS - 1; k++) begin
                r_hist[k] <= r_hist[k + 1];
            end
            r_hist[HIST_ROWS-1] <= i_cur;
            if (i_tag.emit) begin
                r_pix  <= n_pix;
                r_row  <= i_tag.out_row;
                r_last <= i_tag.last;
            end
        end
    end

    assign o_pix  = r_pix;
    assign o_row  = r_row;
    assign o_last = r_last;

endmodule

`default_nettype wire

// ===== hw/rtl/subpixel_sixtap_interpolator.sv =====
// top level of the six-tap subpixel interpolator for one 4x4 block
//
//  channel   direction  handshake                fields
//  s (rows)  in         i_s_tvalid / o_s_tready  tdata: pixel_0..8, frac_col, frac_row
//                                                tuser: block_start
//  m (pels)  out        o_m_tvalid / i_m_tready  tdata: out_0..3, out_row; tlast: last_row
//  cfg       in         i_cfg_valid / o_cfg_ready data: filter_kind
//
// one window row accepted per cycle while the input stage is free; a result reaches the output
// register through the input register, the horizontal stage and the vertical stage
// the row counter sits at the input side; rows past the ninth are dropped there
// a stall on the result side holds the vertical stage, then the earlier stages fill up
// synchronous active-low reset clears counter, valid flags and filter_kind
`default_nettype none

module subpixel_sixtap_interpolator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel_0..pixel_8 [71:0], frac_col [74:72], frac_row [77:75], zero pad
    input  logic [sst_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // block_start
    input  logic                                i_s_tuser,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // out_0..out_3 [31:0], out_row [33:32], zero pad
    output logic [sst_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_data
);
    import sst_pkg::*;

    logic              r_filter_kind;
    logic [CNT_W-1:0]  r_row_count;
    logic              r_s1_valid;
    logic              r_s2_valid;
    logic              r_o_valid;
    t_win              r_s1_win;
    logic [FRAC_W-1:0] r_s1_frac_col;
    t_tag              r_s1_tag;

    t_win              in_win;
    logic              in_acc;
    logic [CNT_W-1:0]  cnt_eff;
    logic [CNT_W-1:0]  out_idx;
    logic              drop;
    t_tag              n_tag;
    logic [CNT_W-1:0]  n_row_count;

    logic              out_free;
    logic              s2_go;
    logic              s2_free;
    logic              s1_go;
    logic              s1_free;

    t_blk_row          s2_cur;
    t_tag              s2_tag;
    t_blk_row          out_pix;
    logic [ROW_W-1:0]  out_row;
    logic              out_last;

    // unpack the window row
    always_comb begin
        for (int k = 0; k < WIN_ROWS; k++) begin
            in_win[k] = i_s_tdata[k*PIX_W +: PIX_W];
        end
    end

    assign in_acc  = i_s_tvalid && o_s_tready;
    assign cnt_eff = i_s_tuser ? '0 : r_row_count;
    assign drop    = (cnt_eff >= CNT_W'(WIN_ROWS));
    assign out_idx = CNT_W'(cnt_eff - CNT_W'(HIST_ROWS));

    always_comb begin
        n_tag.emit     = (cnt_eff >= CNT_W'(HIST_ROWS));
        n_tag.out_row  = out_idx[ROW_W-1:0];
        n_tag.last     = (cnt_eff == CNT_W'(WIN_ROWS - 1));
        n_tag.frac_row = i_s_tdata[FRAC_ROW_LSB +: FRAC_W];
        n_row_count    = drop ? r_row_count : CNT_W'(cnt_eff + 1'b1);
    end

    // stage advance, from the result side back
    assign out_free   = !r_o_valid || i_m_tready;
    assign s2_go      = r_s2_valid && (!s2_tag.emit || out_free);
    assign s2_free    = !r_s2_valid || s2_go;
    assign s1_go      = r_s1_valid && s2_free;
    assign s1_free    = !r_s1_valid || s1_go;
    assign o_s_tready = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_kind <= FK_SIXTAP;
            r_row_count   <= '0;
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_filter_kind <= i_cfg_data;
            end
            if (in_acc) begin
                r_row_count <= n_row_count;
            end
            if (s1_free) begin
                r_s1_valid <= in_acc && !drop;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_free) begin
                r_o_valid <= s2_go && s2_tag.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_win      <= in_win;
            r_s1_frac_col <= i_s_tdata[FRAC_COL_LSB +: FRAC_W];
            r_s1_tag      <= n_tag;
        end
    end

    sst_hpass u_hpass (
        .i_clk      (i_clk),
        .i_load     (s1_go),
        .i_kind     (r_filter_kind),
        .i_win      (r_s1_win),
        .i_frac_col (r_s1_frac_col),
        .i_tag      (r_s1_tag),
        .o_cur      (s2_cur),
        .o_tag      (s2_tag)
    );

    sst_vpass u_vpass (
        .i_clk  (i_clk),
        .i_load (s2_go),
        .i_kind (r_filter_kind),
        .i_cur  (s2_cur),
        .i_tag  (s2_tag),
        .o_pix  (out_pix),
        .o_row  (out_row),
        .o_last (out_last)
    );

    always_comb begin
        o_m_tdata = '0;
        for (int j = 0; j < BLK; j++) begin
            o_m_tdata[j*PIX_W +: PIX_W] = out_pix[j];
        end
        o_m_tdata[OUT_ROW_LSB +: ROW_W] = out_row;
    end

    assign o_m_tlast   = out_last;
    assign o_m_tvalid  = r_o_valid;
    assign o_cfg_ready = 1'b1;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_count <= CNT_W'(WIN_ROWS))
        else $error("row counter beyond window height");

    a_last_is_row3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[OUT_ROW_LSB +: ROW_W] == 2'd3))
        else $error("last row flag on wrong output row");

    a_start_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser) |=> (r_row_count == CNT_W'(1)))
        else $error("block start did not restart row count");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tuser && r_row_count == CNT_W'(WIN_ROWS))
        |=> !r_s1_valid)
        else $error("row past the window entered the pipeline");

endmodule

`default_nettype wire

// ===== test/tb_subpixel_sixtap_interpolator.sv =====
// self-checking testbench for the six-tap subpixel interpolator, directed rows then random blocks
module tb_subpixel_sixtap_interpolator;
    import sst_pkg::*;

    localparam int PIPE_SETTLE    = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // six-tap table, then bilinear table
    localparam int FIR_COEF [0:1][0:7][0:5] = '{
        '{
            '{0,   0, 128,   0,   0, 0},
            '{0,  -6, 123,  12,  -1, 0},
            '{2, -11, 108,  36,  -8, 1},
            '{0,  -9,  93,  50,  -6, 0},
            '{3, -16,  77,  77, -16, 3},
            '{0,  -6,  50,  93,  -9, 0},
            '{1,  -8,  36, 108, -11, 2},
            '{0,  -1,  12, 123,  -6, 0}
        },
        '{
            '{0, 0, 128,   0, 0, 0},
            '{0, 0, 112,  16, 0, 0},
            '{0, 0,  96,  32, 0, 0},
            '{0, 0,  80,  48, 0, 0},
            '{0, 0,  64,  64, 0, 0},
            '{0, 0,  48,  80, 0, 0},
            '{0, 0,  32,  96, 0, 0},
            '{0, 0,  16, 112, 0, 0}
        }
    };

    typedef struct packed {
        t_win              pix;
        logic [FRAC_W-1:0] fcol;
        logic [FRAC_W-1:0] frow;
        logic              start;
    } t_win_row;

    typedef struct packed {
        t_blk_row         pels;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_pel_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   i_s_tuser;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic                   i_cfg_data;

    // predictor state
    logic           kind_now;
    logic [CNT_W-1:0] rows_in_blk;
    t_blk_row       win_hist [0:HIST_ROWS-1];
    t_pel_row       pel_rows_q [$];

    int fail_count;
    int quiet_cycles;
    int src_idle_pct;
    int sink_stall_pct;

    subpixel_sixtap_interpolator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic t_pix fir6(input logic kind, input logic [FRAC_W-1:0] frac,
                                  input t_lane_in v);
        int acc;
        acc = ROUND_ADD;
        for (int k = 0; k < TAPS; k++) acc += int'(v[k]) * FIR_COEF[kind][frac][k];
        if (acc < 0) return '0;
        acc = acc >>> ROUND_SHIFT;
        return (acc > 255) ? t_pix'(255) : t_pix'(acc);
    endfunction

    // one window row into the predictor; queues an output row from the sixth row on
    function automatic void advance_window(input t_win_row r, output bit taken);
        t_blk_row cur;
        t_lane_in lane;
        t_pel_row pr;
        taken = 1'b0;
        if (r.start) rows_in_blk = '0;
        if (rows_in_blk >= WIN_ROWS) return;
        taken = 1'b1;
        for (int j = 0; j < BLK; j++) begin
            for (int k = 0; k < TAPS; k++) lane[k] = r.pix[j+k];
            cur[j] = fir6(kind_now, r.fcol, lane);
        end
        if (rows_in_blk >= HIST_ROWS) begin
            for (int j = 0; j < BLK; j++) begin
                for (int k = 0; k < HIST_ROWS; k++) lane[k] = win_hist[k][j];
                lane[HIST_ROWS] = cur[j];
                pr.pels[j] = fir6(kind_now, r.frow, lane);
            end
            pr.row  = ROW_W'(rows_in_blk - HIST_ROWS);
            pr.last = (rows_in_blk == WIN_ROWS - 1);
            pel_rows_q.push_back(pr);
        end
        for (int i = 0; i < HIST_ROWS - 1; i++) win_hist[i] = win_hist[i+1];
        win_hist[HIST_ROWS-1] = cur;
        rows_in_blk = rows_in_blk + 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d", what, got, want);
        fail_count++;
    endtask

    // result checking and watchdog
    always @(posedge i_clk) begin : result_check
        t_pel_row want;
        bit busy;
        if (i_rst_n) begin
            busy = (i_s_tvalid && o_s_tready) || (i_cfg_valid && o_cfg_ready);
            if (o_m_tvalid && i_m_tready) begin
                busy = 1'b1;
                if (pel_rows_q.size() == 0) begin
                    report_mismatch("output row with nothing pending", 0, 0);
                end else begin
                    want = pel_rows_q.pop_front();
                    for (int j = 0; j < BLK; j++)
                        if (o_m_tdata[j*PIX_W +: PIX_W] !== want.pels[j])
                            report_mismatch($sformatf("out_%0d", j),
                                            int'(o_m_tdata[j*PIX_W +: PIX_W]),
                                            int'(want.pels[j]));
                    if (o_m_tdata[OUT_ROW_LSB +: ROW_W] !== want.row)
                        report_mismatch("out_row", int'(o_m_tdata[OUT_ROW_LSB +: ROW_W]),
                                        int'(want.row));
                    if (o_m_tlast !== want.last)
                        report_mismatch("last_row", int'(o_m_tlast), int'(want.last));
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_row(input t_win_row r, output bit taken);
        logic [IN_TDATA_W-1:0] word;
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        word = '0;
        for (int c = 0; c < WIN_ROWS; c++) word[c*PIX_W +: PIX_W] = r.pix[c];
        word[FRAC_COL_LSB +: FRAC_W] = r.fcol;
        word[FRAC_ROW_LSB +: FRAC_W] = r.frow;
        i_s_tdata  <= word;
        i_s_tuser  <= r.start;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        advance_window(r, taken);
        @(negedge i_clk);
    endtask

    task automatic wait_quiet();
        i_s_tvalid <= 1'b0;
        while (pel_rows_q.size() != 0) @(negedge i_clk);
        // rows that give no output may still be in flight
        repeat (PIPE_SETTLE) @(negedge i_clk);
    endtask

    task automatic set_filter_kind(input logic kind);
        wait_quiet();
        i_cfg_data  <= kind;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        kind_now = kind;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_pix rand_pel(input int style);
        if (style < 7) return t_pix'($urandom_range(255));
        if (style < 9) return $urandom_range(1) ? t_pix'(255) : t_pix'(0);
        return t_pix'($urandom_range(140, 116));
    endfunction

    // rows before any block start, all fractions, clamping both ways, extra rows,
    // early restart of a block
    task automatic test_directed();
        t_win_row r;
        bit taken;
        for (int i = 0; i < 23; i++) begin
            for (int c = 0; c < WIN_ROWS; c++) begin
                case (i % 5)
                    0: r.pix[c] = '0;
                    1: r.pix[c] = 8'd255;
                    2: r.pix[c] = (c % 3 == 1) ? 8'd255 : 8'd0;
                    3: r.pix[c] = (c % 3 == 1) ? 8'd0 : 8'd255;
                    default: r.pix[c] = t_pix'($urandom_range(255));
                endcase
            end
            r.fcol  = FRAC_W'(i);
            r.frow  = FRAC_W'(i * 3);
            // rows 9 and 10 trail a full block, row 11 starts a block cut short at 14
            r.start = (i == 11) || (i == 14);
            send_row(r, taken);
        end
    endtask

    task automatic test_random_phase(input logic kind, input int src_pct, input int sink_pct,
                                     input int n_rows);
        t_win_row r;
        bit taken;
        int taken_total;
        int sel;
        int style;
        int blk_len;
        logic [FRAC_W-1:0] fc;
        logic [FRAC_W-1:0] fr;
        set_filter_kind(kind);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        taken_total    = 0;
        while (taken_total < n_rows) begin
            sel     = $urandom_range(99);
            style   = $urandom_range(9);
            fc      = FRAC_W'($urandom_range(7));
            fr      = FRAC_W'($urandom_range(7));
            blk_len = (sel < 8) ? $urandom_range(8, 1) : WIN_ROWS;
            for (int i = 0; i < blk_len; i++) begin
                for (int c = 0; c < WIN_ROWS; c++) r.pix[c] = rand_pel(style);
                r.start = (i == 0) || (sel >= 8 && sel < 12 && $urandom_range(7) == 0);
                r.fcol  = (sel >= 88) ? FRAC_W'($urandom_range(7)) : fc;
                r.frow  = (sel >= 88) ? FRAC_W'($urandom_range(7)) : fr;
                send_row(r, taken);
                taken_total += taken;
            end
            // stray rows after a block without a new start
            if (sel >= 92) begin
                repeat ($urandom_range(3, 1)) begin
                    for (int c = 0; c < WIN_ROWS; c++) r.pix[c] = rand_pel(style);
                    r.fcol  = FRAC_W'($urandom_range(7));
                    r.frow  = FRAC_W'($urandom_range(7));
                    r.start = 1'b0;
                    send_row(r, taken);
                    taken_total += taken;
                end
            end
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = 1'b0;
        i_s_tvalid     = 1'b0;
        i_m_tready     = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = FK_SIXTAP;
        kind_now       = FK_SIXTAP;
        rows_in_blk    = '0;
        for (int i = 0; i < HIST_ROWS; i++) win_hist[i] = '0;
        fail_count     = 0;
        quiet_cycles   = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phase(FK_BILINEAR, 0, 0, 256);
        test_random_phase(FK_SIXTAP, 68, 0, 256);
        test_random_phase(FK_BILINEAR, 0, 68, 256);
        test_random_phase(FK_SIXTAP, 25, 25, 256);
        test_random_phase(FK_BILINEAR, 25, 25, 256);

        wait_quiet();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
